// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks a condition at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// checks that a condition leads to a consequence in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// checks that a condition leads to a consequence in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/lvi_pkg.sv =====
`timescale 1ns / 1ps
package lvi_pkg;
   localparam int FRAC_BITS   = 4;
   localparam int COORD_W     = 14;
   localparam int DELTA_W     = 15;
   localparam int STEP_W      = 11;
   localparam int SQ_W        = 29;
   localparam int ROOT_ITERS  = 15;
   localparam int ITER_W      = 4;
   localparam int QUOT_W      = 14;
   localparam int PROD_W      = 26;
   localparam int POS_W       = 17;
   localparam int CODE_W      = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int STEP_MAX    = 2047;
   localparam logic [CODE_W-1:0] CODE_MAX = 8'd255;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef enum logic {
      CSR_MIRROR_X = 1'b0,
      CSR_MIRROR_Y = 1'b1
   } csr_type;

   typedef struct packed {
      op_type                     op;
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
   } item_type;

   // position in sub-pixel units to a clamped dac code
   function automatic logic [CODE_W-1:0] to_code(input logic signed [POS_W-1:0] pos);
      logic [POS_W-FRAC_BITS-1:0] pix;
      pix = pos[POS_W-1:FRAC_BITS];
      if (pos[POS_W-1])
         return '0;
      else if (pix > (POS_W-FRAC_BITS)'(CODE_MAX))
         return CODE_MAX;
      else
         return pix[CODE_W-1:0];
   endfunction
endpackage

// ===== hdl/lvi_if.sv =====
`timescale 1ns / 1ps
interface lvi_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic signed [13:0] start_x;
   logic signed [13:0] start_y;
   logic signed [13:0] end_x;
   logic signed [13:0] end_y;
   modport source (output valid, op, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lvi_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] dac_x;
   logic [7:0] dac_y;
   logic       last_point;
   modport source (output valid, dac_x, dac_y, last_point, input ready);
   modport sink   (input valid, dac_x, dac_y, last_point, output ready);
endinterface

// ===== hdl/lvi_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lvi_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  lvi_pkg::item_type  push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output lvi_pkg::item_type  pop_item
);
   import lvi_pkg::*;

   item_type   entry_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push_go;
   logic       pop_go;

   assign push_ready = (count_ff != 2'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push_go    = push_valid && push_ready;
   assign pop_go     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push_go) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push_go) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop_go)  rd_ptr_ff <= ~rd_ptr_ff;
         if (push_go && !pop_go)      count_ff <= count_ff + 2'd1;
         else if (pop_go && !push_go) count_ff <= count_ff - 2'd1;
      end
   end

   `ASSERT_ALWAYS(a_count_range, count_ff <= 2'(QUEUE_DEPTH), "queue count out of range")
   `ASSERT_NEXT(a_ptr_sync, count_ff == '0 && !push_go, wr_ptr_ff == rd_ptr_ff,
                "pointers apart while queue empty")
endmodule

// ===== hdl/lvi_engine.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lvi_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  lvi_pkg::item_type  pop_item,
   input  logic               mirror_x,
   input  logic               mirror_y,
   lvi_rsp_if.source          rsp
);
   import lvi_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQUARE, ST_SUM, ST_ROOT, ST_STORE,
      ST_PRODUCT, ST_DIVIDE, ST_EMIT
   } state_type;

   state_type                  state_ff;
   logic [ITER_W-1:0]          iter_ff;
   logic                       seg_active_ff;
   logic signed [COORD_W-1:0]  origin_x_ff, origin_y_ff, pend_x_ff, pend_y_ff;
   logic signed [DELTA_W-1:0]  delta_x_ff, delta_y_ff, dx_ff, dy_ff;
   logic [STEP_W-1:0]          step_total_ff, step_index_ff;
   logic [SQ_W-1:0]            sqx_ff, sqy_ff, rem_ff, res_ff;
   logic                       neg_x_ff, neg_y_ff;
   logic [QUOT_W-1:0]          nlo_x_ff, nlo_y_ff, q_x_ff, q_y_ff;
   logic [STEP_W-1:0]          p_x_ff, p_y_ff;
   logic                       rsp_valid_ff;
   logic [CODE_W-1:0]          dac_x_ff, dac_y_ff;
   logic                       last_ff;

   logic [SQ_W-1:0]            bit_in, trial_in;
   logic signed [2*DELTA_W-1:0] sqx_in, sqy_in;
   logic [STEP_W+5:0]          r5_in;
   logic [STEP_W+5:0]          steps_in;
   logic signed [PROD_W-1:0]   prod_x_in, prod_y_in;
   logic [PROD_W-1:0]          mag_x_in, mag_y_in;
   logic [STEP_W:0]            px_shift_in, py_shift_in;
   logic signed [POS_W-1:0]    qs_x_in, qs_y_in, pos_x_in, pos_y_in;
   logic [CODE_W-1:0]          code_x_in, code_y_in;
   logic                       emit_go;

   assign pop_ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.dac_x      = dac_x_ff;
   assign rsp.dac_y      = dac_y_ff;
   assign rsp.last_point = last_ff;

   always_comb begin
      bit_in    = SQ_W'(1) << {iter_ff, 1'b0};
      trial_in  = res_ff + bit_in;
      sqx_in    = dx_ff * dx_ff;
      sqy_in    = dy_ff * dy_ff;
      // steps are 2.5 per pixel of the root, which is in sub-pixel units
      r5_in     = (STEP_W+6)'(res_ff[ROOT_ITERS-1:0])
                + (STEP_W+6)'({res_ff[ROOT_ITERS-1:0], 2'b00});
      steps_in  = r5_in >> (FRAC_BITS + 1);
      prod_x_in = $signed({1'b0, step_index_ff}) * delta_x_ff;
      prod_y_in = $signed({1'b0, step_index_ff}) * delta_y_ff;
      mag_x_in  = sqx_ff[PROD_W-1] ? PROD_W'(-$signed(sqx_ff[PROD_W-1:0])) : sqx_ff[PROD_W-1:0];
      mag_y_in  = sqy_ff[PROD_W-1] ? PROD_W'(-$signed(sqy_ff[PROD_W-1:0])) : sqy_ff[PROD_W-1:0];
      px_shift_in = {p_x_ff, nlo_x_ff[iter_ff]};
      py_shift_in = {p_y_ff, nlo_y_ff[iter_ff]};
      // floor division rounds a negative quotient with a remainder one lower
      qs_x_in = neg_x_ff ? -$signed(POS_W'(q_x_ff)) - POS_W'(p_x_ff != '0)
                         : $signed(POS_W'(q_x_ff));
      qs_y_in = neg_y_ff ? -$signed(POS_W'(q_y_ff)) - POS_W'(p_y_ff != '0)
                         : $signed(POS_W'(q_y_ff));
      pos_x_in  = POS_W'(origin_x_ff) + qs_x_in;
      pos_y_in  = $signed(POS_W'(CODE_MAX) << FRAC_BITS) - POS_W'(origin_y_ff) + qs_y_in;
      code_x_in = mirror_x ? CODE_MAX - to_code(pos_x_in) : to_code(pos_x_in);
      code_y_in = mirror_y ? CODE_MAX - to_code(pos_y_in) : to_code(pos_y_in);
      emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         iter_ff       <= '0;
         seg_active_ff <= 1'b0;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         delta_x_ff    <= '0;
         delta_y_ff    <= '0;
         step_total_ff <= '0;
         step_index_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && !emit_go) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (pop_valid) begin
                  if (pop_item.op == OP_LOAD) begin
                     dx_ff     <= DELTA_W'(pop_item.end_x) - DELTA_W'(pop_item.start_x);
                     dy_ff     <= DELTA_W'(pop_item.start_y) - DELTA_W'(pop_item.end_y);
                     pend_x_ff <= pop_item.start_x;
                     pend_y_ff <= pop_item.start_y;
                     state_ff  <= ST_SQUARE;
                  end else if (seg_active_ff) begin
                     state_ff <= ST_PRODUCT;
                  end
               end
            end
            ST_SQUARE: begin
               sqx_ff   <= SQ_W'(sqx_in);
               sqy_ff   <= SQ_W'(sqy_in);
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               rem_ff   <= sqx_ff + sqy_ff;
               res_ff   <= '0;
               iter_ff  <= ITER_W'(ROOT_ITERS - 1);
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (rem_ff >= trial_in) begin
                  rem_ff <= rem_ff - trial_in;
                  res_ff <= (res_ff >> 1) + bit_in;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               if (iter_ff == '0) state_ff <= ST_STORE;
               else               iter_ff  <= iter_ff - ITER_W'(1);
            end
            ST_STORE: begin
               origin_x_ff   <= pend_x_ff;
               origin_y_ff   <= pend_y_ff;
               delta_x_ff    <= dx_ff;
               delta_y_ff    <= dy_ff;
               if (steps_in == '0)
                  step_total_ff <= STEP_W'(1);
               else if (steps_in > (STEP_W+6)'(STEP_MAX))
                  step_total_ff <= STEP_W'(STEP_MAX);
               else
                  step_total_ff <= steps_in[STEP_W-1:0];
               step_index_ff <= '0;
               seg_active_ff <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            ST_PRODUCT: begin
               // products parked in the square registers for the divide setup
               sqx_ff   <= SQ_W'(prod_x_in);
               sqy_ff   <= SQ_W'(prod_y_in);
               state_ff <= ST_DIVIDE;
               iter_ff  <= ITER_W'(QUOT_W);
            end
            ST_DIVIDE: begin
               if (iter_ff == ITER_W'(QUOT_W)) begin
                  neg_x_ff <= sqx_ff[PROD_W-1];
                  neg_y_ff <= sqy_ff[PROD_W-1];
                  p_x_ff   <= mag_x_in[PROD_W-2:QUOT_W];
                  p_y_ff   <= mag_y_in[PROD_W-2:QUOT_W];
                  nlo_x_ff <= mag_x_in[QUOT_W-1:0];
                  nlo_y_ff <= mag_y_in[QUOT_W-1:0];
                  iter_ff  <= ITER_W'(QUOT_W - 1);
               end else begin
                  if (px_shift_in >= {1'b0, step_total_ff}) begin
                     p_x_ff           <= STEP_W'(px_shift_in - {1'b0, step_total_ff});
                     q_x_ff[iter_ff]  <= 1'b1;
                  end else begin
                     p_x_ff           <= px_shift_in[STEP_W-1:0];
                     q_x_ff[iter_ff]  <= 1'b0;
                  end
                  if (py_shift_in >= {1'b0, step_total_ff}) begin
                     p_y_ff           <= STEP_W'(py_shift_in - {1'b0, step_total_ff});
                     q_y_ff[iter_ff]  <= 1'b1;
                  end else begin
                     p_y_ff           <= py_shift_in[STEP_W-1:0];
                     q_y_ff[iter_ff]  <= 1'b0;
                  end
                  if (iter_ff == '0) state_ff <= ST_EMIT;
                  else               iter_ff  <= iter_ff - ITER_W'(1);
               end
            end
            ST_EMIT: begin
               if (emit_go) begin
                  rsp_valid_ff <= 1'b1;
                  dac_x_ff     <= code_x_in;
                  dac_y_ff     <= code_y_in;
                  last_ff      <= (step_index_ff >= step_total_ff);
                  if (step_index_ff >= step_total_ff) seg_active_ff <= 1'b0;
                  else step_index_ff <= step_index_ff + STEP_W'(1);
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `ASSERT_IMPLIES(a_total_set, seg_active_ff, step_total_ff != '0,
                   "active segment with zero step count")
   `ASSERT_IMPLIES(a_index_range, seg_active_ff, step_index_ff <= step_total_ff,
                   "step index past step count")
   `ASSERT_NEXT(a_divide_done, state_ff == ST_DIVIDE && iter_ff == '0, state_ff == ST_EMIT,
                "divide did not hand over to emit")
   `ASSERT_NEXT(a_emit_slot, emit_go, rsp_valid_ff,
                "emitted point not shown on the output")
endmodule

// ===== hdl/xy_vector_line_interpolator.sv =====
`timescale 1ns / 1ps
// channel   | direction | transaction
// req_chan  | in        | op, start_x, start_y, end_x, end_y
// rsp_chan  | out       | dac_x, dac_y, last_point
// csr       | in        | csr_we, csr_index, csr_wdata (no read-back)
// a load in the back end runs square, sum, a 15-step integer root and the store
// a point runs multiply, divide setup, a 14-step divide for x and y, the emit
// a two-entry queue lets the input run ahead; the output register frees the divider
// reset is synchronous; mirror_x comes up 1, mirror_y 0, no segment loaded
// a held output stalls the back end only when the next point is ready to leave
module xy_vector_line_interpolator (
   input  logic       clock,
   input  logic       reset,
   lvi_req_if.sink    req_chan,
   lvi_rsp_if.source  rsp_chan,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic       csr_wdata
);
   import lvi_pkg::*;

   logic     mirror_x_ff;
   logic     mirror_y_ff;
   item_type push_item;
   item_type pop_item;
   logic     pop_valid;
   logic     pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_x_ff <= 1'b1;
         mirror_y_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIRROR_X: mirror_x_ff <= csr_wdata;
            CSR_MIRROR_Y: mirror_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      push_item.op      = op_type'(req_chan.op);
      push_item.start_x = req_chan.start_x;
      push_item.start_y = req_chan.start_y;
      push_item.end_x   = req_chan.end_x;
      push_item.end_y   = req_chan.end_y;
   end

   lvi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_chan.valid),
      .push_ready (req_chan.ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   lvi_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .mirror_x  (mirror_x_ff),
      .mirror_y  (mirror_y_ff),
      .rsp       (rsp_chan)
   );
endmodule
